[rtl/rrlp_pkg.sv]
// shared types and constants for the round-robin lag priority unit
// no dependencies
package rrlp_pkg;

  localparam int NUM_OPERATORS_DEF = 64;
  localparam int NUM_PIPELINES_DEF = 8;
  localparam int ROUND_BITS_DEF    = 32;
  localparam int OP_W  = 6;
  localparam int PL_W  = 3;
  localparam int WT_W  = 7;
  localparam int CNT_W = 7;
  localparam int FRONT_Q_DEPTH = 2;

  typedef enum logic [2:0] {
    REQ_QUERY    = 3'd0,
    REQ_COMPLETE = 3'd1,
    REQ_REGISTER = 3'd2,
    REQ_ACTIVATE = 3'd3,
    REQ_DEACT    = 3'd4
  } req_e;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [OP_W-1:0] op_index;
    logic [PL_W-1:0] pipeline_index;
    logic [WT_W-1:0] level_weight;
  } req_t;

  typedef struct packed {
    logic [31:0] priority_q16;
    logic        status;
  } rsp_t;

  // request after classification in the front part
  typedef struct packed {
    req_e            kind;
    logic            bad;
    logic [OP_W-1:0] op;
    logic [PL_W-1:0] pl;
    logic [WT_W-1:0] wt;
  } cmd_t;

endpackage

[rtl/rrlp_front.sv]
// front part: decodes and range-checks requests, holds them in a short queue
// depends on rrlp_pkg
module rrlp_front #(
  parameter int NUM_OPERATORS = rrlp_pkg::NUM_OPERATORS_DEF,
  parameter int NUM_PIPELINES = rrlp_pkg::NUM_PIPELINES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  rrlp_pkg::req_t in_req,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output rrlp_pkg::cmd_t cmd
);
  import rrlp_pkg::*;

  localparam int QA_W = $clog2(FRONT_Q_DEPTH);

  cmd_t            q [FRONT_Q_DEPTH];
  logic [QA_W-1:0] wr_ptr, rd_ptr;
  logic [QA_W:0]   fill;
  cmd_t            dec;
  logic            op_ok, pl_ok;

  always_comb begin
    op_ok = 32'(in_req.op_index) < NUM_OPERATORS;
    pl_ok = 32'(in_req.pipeline_index) < NUM_PIPELINES;
    dec.op = in_req.op_index;
    dec.pl = in_req.pipeline_index;
    dec.wt = in_req.level_weight;
    dec.kind = REQ_QUERY;
    dec.bad = 1'b1;
    unique case (in_req.req_type)
      REQ_QUERY, REQ_COMPLETE: begin
        dec.kind = req_e'(in_req.req_type);
        dec.bad = !op_ok;
      end
      REQ_REGISTER: begin
        dec.kind = REQ_REGISTER;
        dec.bad = !op_ok || !pl_ok;
      end
      REQ_ACTIVATE, REQ_DEACT: begin
        dec.kind = req_e'(in_req.req_type);
        dec.bad = !pl_ok;
      end
      default: dec.bad = 1'b1;
    endcase
  end

  assign full = fill == (QA_W+1)'(FRONT_Q_DEPTH);
  assign cmd_valid = fill != '0;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (cmd_take && cmd_valid) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QA_W+1)'(push && !full) - (QA_W+1)'(cmd_take && cmd_valid);
    end
  end

endmodule

[rtl/rrlp_back.sv]
// back part: operator and pipeline state, round scan, divider, result register
// depends on rrlp_pkg
module rrlp_back #(
  parameter int NUM_OPERATORS = rrlp_pkg::NUM_OPERATORS_DEF,
  parameter int NUM_PIPELINES = rrlp_pkg::NUM_PIPELINES_DEF,
  parameter int ROUND_BITS    = rrlp_pkg::ROUND_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  rrlp_pkg::cmd_t cmd,
  output logic           empty,
  input  logic           pop,
  output rrlp_pkg::rsp_t rsp
);
  import rrlp_pkg::*;

  localparam int IDX_W = (NUM_OPERATORS > (1 << OP_W)) ? OP_W : $clog2(NUM_OPERATORS);
  localparam int PIX_W = (NUM_PIPELINES > (1 << PL_W)) ? PL_W :
                         ((NUM_PIPELINES > 1) ? $clog2(NUM_PIPELINES) : 1);
  localparam int NUM_SLOTS = 1 << IDX_W;
  localparam int SCAN_N = (NUM_OPERATORS < NUM_SLOTS) ? NUM_OPERATORS : NUM_SLOTS;
  localparam int DIV_N = WT_W + 16;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_RD     = 8'b00000010,
    S_DECIDE = 8'b00000100,
    S_SCAN   = 8'b00001000,
    S_SCHK   = 8'b00010000,
    S_LAG    = 8'b00100000,
    S_DIV    = 8'b01000000,
    S_OUT    = 8'b10000000
  } state_e;

  state_e state;

  // per-operator memories
  logic [ROUND_BITS-1:0] round_mem [NUM_SLOTS];
  logic [PL_W-1:0]       pipe_mem  [NUM_SLOTS];
  logic [WT_W-1:0]       wt_mem    [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  op_valid;

  logic [NUM_PIPELINES-1:0] pipe_active;
  logic [CNT_W-1:0]         pipe_cnt [NUM_PIPELINES];
  logic [ROUND_BITS-1:0]    global_round;
  logic [CNT_W-1:0]         active_total;

  cmd_t                  cur;
  logic [IDX_W-1:0]      cur_idx;
  logic [PIX_W-1:0]      cur_pl;
  logic [ROUND_BITS-1:0] rd_round;
  logic [PL_W-1:0]       rd_pipe;
  logic [WT_W-1:0]       rd_wt;
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [ROUND_BITS-1:0] wr_round;
  logic [IDX_W-1:0]      scan;
  logic                  scan_ok;
  logic [ROUND_BITS-1:0] scan_diff;
  logic [ROUND_BITS-1:0] next_global;
  logic [ROUND_BITS-1:0] lag_diff;
  logic [15:0]           lag_sat;
  logic [15:0]           lag;
  logic [DIV_N-1:0]      quo;
  logic [CNT_W:0]        rem;
  logic [4:0]            div_cnt;
  logic [CNT_W:0]        rem_sh;
  logic                  out_full;
  logic [31:0]           out_prio;
  logic                  out_stat;
  logic                  op_in;
  logic [32:0]           sum;
  logic                  pl_act;
  logic                  calc;
  logic                  dec_err, dec_scan;

  assign cur_idx = cur.op[IDX_W-1:0];
  assign cur_pl = cur.pl[PIX_W-1:0];
  assign op_in = 32'(cur.op) < NUM_OPERATORS;
  assign cmd_take = (state == S_IDLE) && !out_full;
  assign empty = !out_full;
  assign rsp.priority_q16 = out_prio;
  assign rsp.status = out_stat;
  // the scan reads one slot per pass; every other read targets the current operator
  assign rd_addr = (state == S_SCAN) ? scan : cur_idx;
  assign rd_en = (state == S_RD) || (state == S_SCAN) || (state == S_SCHK);
  assign pl_act = 32'(rd_pipe) < NUM_PIPELINES && pipe_active[rd_pipe[PIX_W-1:0]];
  assign scan_diff = rd_round - global_round;
  assign next_global = global_round + ROUND_BITS'(scan_ok);
  assign lag_diff = next_global - rd_round;
  assign rem_sh = {rem[CNT_W-1:0], quo[DIV_N-1]};
  assign sum = {1'b0, lag, 16'h0} + 33'(quo);

  always_comb begin
    if (lag_diff[ROUND_BITS-1]) lag_sat = '0;
    else if (64'(lag_diff) > 64'd65535) lag_sat = 16'hFFFF;
    else lag_sat = 16'(64'(lag_diff));
  end

  always_comb begin
    dec_err = 1'b0;
    dec_scan = 1'b0;
    if (cur.bad) begin
      dec_err = 1'b1;
    end else if (cur.kind == REQ_QUERY || cur.kind == REQ_COMPLETE) begin
      if (!op_in || !op_valid[cur_idx]) dec_err = 1'b1;
      else if (cur.kind == REQ_QUERY && pl_act) dec_scan = 1'b1;
    end
  end

  // registered reads of the operator memories
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_round <= round_mem[rd_addr];
      rd_pipe  <= pipe_mem[rd_addr];
      rd_wt    <= wt_mem[rd_addr];
    end
    if (wr_en) begin
      round_mem[cur_idx] <= wr_round;
      if (cur.kind == REQ_REGISTER) begin
        pipe_mem[cur_idx] <= cur.pl;
        wt_mem[cur_idx] <= cur.wt;
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_round = rd_round + 1'b1;
    if (state == S_DECIDE && !cur.bad && op_in) begin
      if (cur.kind == REQ_COMPLETE && op_valid[cur_idx]) wr_en = 1'b1;
      if (cur.kind == REQ_REGISTER && !op_valid[cur_idx]) begin
        wr_en = 1'b1;
        wr_round = global_round;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_valid <= '0;
      pipe_active <= '0;
      for (int p = 0; p < NUM_PIPELINES; p++) pipe_cnt[p] <= '0;
      global_round <= '0;
      active_total <= '0;
      out_full <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && !out_full) begin
            cur <= cmd;
            state <= S_RD;
          end
        end
        S_RD: state <= S_DECIDE;
        S_DECIDE: begin
          out_prio <= '0;
          out_stat <= dec_err;
          calc <= dec_scan;
          scan <= '0;
          scan_ok <= 1'b1;
          state <= dec_scan ? S_SCAN : S_OUT;
          if (!cur.bad) begin
            case (cur.kind)
              REQ_REGISTER: begin
                if (!op_valid[cur_idx]) begin
                  op_valid[cur_idx] <= 1'b1;
                  pipe_cnt[cur_pl] <= pipe_cnt[cur_pl] + 1'b1;
                  if (pipe_active[cur_pl]) active_total <= active_total + 1'b1;
                end
              end
              REQ_ACTIVATE: begin
                if (!pipe_active[cur_pl]) begin
                  pipe_active[cur_pl] <= 1'b1;
                  active_total <= active_total + pipe_cnt[cur_pl];
                end
              end
              REQ_DEACT: begin
                if (pipe_active[cur_pl]) begin
                  pipe_active[cur_pl] <= 1'b0;
                  active_total <= active_total - pipe_cnt[cur_pl];
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: state <= S_SCHK;
        // data of the scanned slot is here; the read in this cycle fetches cur again
        S_SCHK: begin
          if (op_valid[scan] && pl_act && scan_diff[ROUND_BITS-1]) scan_ok <= 1'b0;
          if (scan == IDX_W'(SCAN_N - 1)) begin
            state <= S_LAG;
          end else begin
            scan <= scan + 1'b1;
            state <= S_SCAN;
          end
        end
        S_LAG: begin
          global_round <= next_global;
          lag <= lag_sat;
          quo <= {rd_wt, 16'h0};
          rem <= '0;
          div_cnt <= '0;
          state <= S_DIV;
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (rem_sh >= {1'b0, active_total}) begin
            rem <= rem_sh - {1'b0, active_total};
            quo <= {quo[DIV_N-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DIV_N-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 5'(DIV_N - 1)) state <= S_OUT;
        end
        S_OUT: begin
          out_full <= 1'b1;
          state <= S_IDLE;
          if (calc) begin
            if (active_total == '0 || sum[32]) out_prio <= 32'hFFFF_FFFF;
            else out_prio <= sum[31:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/round_robin_lag_priority_unit.sv]
// top level of the round-robin lag priority unit
// depends on rrlp_pkg, rrlp_front, rrlp_back
// A request other than a valid query on an active pipeline goes from acceptance
// through the read and decide states straight to the output state; such a query
// also passes the scan of the operator round memory, reading and checking each slot,
// and the bit-serial weight divider. Requests queue in a two-entry front queue and
// each gives one result, held until popped; the next request starts only after that.
module round_robin_lag_priority_unit #(
  parameter int NUM_OPERATORS = rrlp_pkg::NUM_OPERATORS_DEF,
  parameter int NUM_PIPELINES = rrlp_pkg::NUM_PIPELINES_DEF,
  parameter int ROUND_BITS    = rrlp_pkg::ROUND_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  rrlp_pkg::req_t in_data,
  output logic           empty,
  input  logic           pop,
  output rrlp_pkg::rsp_t out_data
);
  import rrlp_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  rrlp_front #(.NUM_OPERATORS(NUM_OPERATORS), .NUM_PIPELINES(NUM_PIPELINES)) u_front (
    .clk, .rst, .push, .full, .in_req(in_data), .cmd_valid, .cmd_take, .cmd
  );

  rrlp_back #(.NUM_OPERATORS(NUM_OPERATORS), .NUM_PIPELINES(NUM_PIPELINES),
              .ROUND_BITS(ROUND_BITS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd, .empty, .pop, .rsp(out_data)
  );

`ifndef NO_ASSERTIONS
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> empty) else $error("take with result waiting");
  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> empty) else $error("result repeated");
`endif

endmodule
